### rtl/kfc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package kfc_pkg;

  localparam int unsigned MAX_WINDOW   = 1024;
  localparam int unsigned MAX_ORDER    = 2;
  localparam int unsigned NUM_BASES    = 4;
  localparam int unsigned NUM_COUNTERS = 20;
  localparam int unsigned JOB_DEPTH    = 2;

  localparam int unsigned SYM_W   = 3;
  localparam int unsigned CNT_W   = 11;
  localparam int unsigned WIN_W   = 11;
  localparam int unsigned ORD_W   = 2;
  localparam int unsigned IDX_W   = 4;
  localparam int unsigned SLOT_W  = 5;
  localparam int unsigned FRAC_W  = 16;
  localparam int unsigned FREQ_W  = 17;
  localparam int unsigned NUM_W   = CNT_W + FRAC_W;
  localparam int unsigned STEP_W  = $clog2(NUM_W);
  localparam int unsigned CFG_W   = 11;

  localparam logic [SYM_W-1:0] NO_BASE = 3'd4;

  typedef enum logic [0:0] {
    REG_WINDOW_LENGTH = 1'b0,
    REG_MAX_ORDER     = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [SYM_W-1:0] base_symbol;
    logic             seq_last;
  } in_t;

  typedef struct packed {
    logic [ORD_W-1:0]  kmer_order;
    logic [IDX_W-1:0]  kmer_index;
    logic [CNT_W-1:0]  match_count;
    logic [FREQ_W-1:0] frequency;
    logic              run_last;
  } res_t;

  typedef struct packed {
    logic [NUM_COUNTERS-1:0][CNT_W-1:0] counts;
    logic [WIN_W-1:0]                   window;
    logic [ORD_W-1:0]                   order;
  } job_t;

endpackage
`default_nettype wire

### rtl/kmer_frequency_counter_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// k-mer frequency counter.
// Symbols enter on the push/full side, one per cycle while full is low; a
// sequence ends with seq_last. Only the first window_length symbols count.
// Counting happens in the front end in the cycle a symbol is taken.
// On the last symbol the counter snapshot moves into a two-entry job queue
// and the front end is ready for the next sequence at once; full rises only
// when both job entries are waiting.
// The back end walks a job's k-mers in order (4 results for order 1, 20 for
// order 2) and divides each count by window-k+1 with a radix-2 divider, one
// k-mer at a time: the next division starts only once the last quotient has
// gone into the result register. Results are read on the empty/pop side. If
// the receiver does not pop, the result register holds and the back end waits
// with the next quotient ready; the front end keeps counting until the job
// queue is full.
// Configuration writes are registered and apply from the next symbol.
// Reset clears all counters, empties the job queue and the result register,
// and sets window_length to 2 and max_order to 2.
module kmer_frequency_counter_unit #(
  parameter int unsigned MAX_ORDER = kfc_pkg::MAX_ORDER
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       push,
  output logic                            full,
  input  wire kfc_pkg::in_t               in_data_i,
  output logic                            empty,
  input  wire logic                       pop,
  output kfc_pkg::res_t                   res_data_o,
  input  wire logic                       cfg_we_i,
  input  wire logic [0:0]                 cfg_index_i,
  input  wire logic [kfc_pkg::CFG_W-1:0]  cfg_wdata_i
);

  logic [kfc_pkg::WIN_W-1:0] window_length_q, window_length_d, win_eff;
  logic [kfc_pkg::ORD_W-1:0] max_order_q, max_order_d, ord_eff;
  logic                      accept;
  logic                      job_push, job_pop, job_full, job_empty, res_valid;
  kfc_pkg::job_t             job_in, job_head;

  always_comb begin
    window_length_d = window_length_q;
    max_order_d     = max_order_q;
    if (cfg_we_i) begin
      unique case (kfc_pkg::cfg_idx_e'(cfg_index_i))
        kfc_pkg::REG_WINDOW_LENGTH: window_length_d = cfg_wdata_i[kfc_pkg::WIN_W-1:0];
        kfc_pkg::REG_MAX_ORDER:     max_order_d     = cfg_wdata_i[kfc_pkg::ORD_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_length_q <= kfc_pkg::WIN_W'(2);
      max_order_q     <= kfc_pkg::ORD_W'(2);
    end else begin
      window_length_q <= window_length_d;
      max_order_q     <= max_order_d;
    end
  end

  // clamp registers into their legal ranges
  always_comb begin
    priority if (window_length_q == '0) begin
      win_eff = kfc_pkg::WIN_W'(1);
    end else if (32'(window_length_q) > kfc_pkg::MAX_WINDOW) begin
      win_eff = kfc_pkg::WIN_W'(kfc_pkg::MAX_WINDOW);
    end else begin
      win_eff = window_length_q;
    end
    priority if (max_order_q == '0) begin
      ord_eff = kfc_pkg::ORD_W'(1);
    end else if (32'(max_order_q) > MAX_ORDER) begin
      ord_eff = kfc_pkg::ORD_W'(MAX_ORDER);
    end else begin
      ord_eff = max_order_q;
    end
  end

  assign full   = job_full;
  assign accept = push && !job_full;

  kfc_front #(
    .MaxOrder(MAX_ORDER)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .sym_i      (in_data_i),
    .window_i   (win_eff),
    .order_i    (ord_eff),
    .job_push_o (job_push),
    .job_o      (job_in)
  );

  kfc_job_fifo #(
    .Depth(kfc_pkg::JOB_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .data_i  (job_in),
    .pop_i   (job_pop),
    .head_o  (job_head),
    .full_o  (job_full),
    .empty_o (job_empty)
  );

  kfc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (!job_empty),
    .job_i       (job_head),
    .job_pop_o   (job_pop),
    .pop_i       (pop),
    .res_o       (res_data_o),
    .res_valid_o (res_valid)
  );

  assign empty = !res_valid;

endmodule
`default_nettype wire

### rtl/kfc_front.sv
`timescale 1ns / 1ps
`default_nettype none
module kfc_front #(
  parameter int unsigned MaxOrder = kfc_pkg::MAX_ORDER
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        accept_i,
  input  wire kfc_pkg::in_t                sym_i,
  input  wire logic [kfc_pkg::WIN_W-1:0]   window_i,
  input  wire logic [kfc_pkg::ORD_W-1:0]   order_i,
  output logic                             job_push_o,
  output kfc_pkg::job_t                    job_o
);

  localparam int unsigned N = kfc_pkg::NUM_COUNTERS;

  logic [N-1:0][kfc_pkg::CNT_W-1:0] cnt_q, cnt_d, cnt_inc, cnt_upd;
  logic [kfc_pkg::SYM_W-1:0]        prev_q, prev_d;
  logic [kfc_pkg::WIN_W-1:0]        pos_q, pos_d;
  logic                             in_win, sym_ok, pair_ok;
  logic [kfc_pkg::SLOT_W-1:0]       pair_idx;
  logic                             hit;

  assign in_win   = pos_q < window_i;
  assign sym_ok   = !sym_i.base_symbol[2];
  assign pair_ok  = (MaxOrder >= 2) && sym_ok && !prev_q[2];
  assign pair_idx = kfc_pkg::SLOT_W'(kfc_pkg::NUM_BASES)
                  + {1'b0, prev_q[1:0], sym_i.base_symbol[1:0]};

  always_comb begin
    hit = 1'b0;
    for (int i = 0; i < N; i++) begin
      if (i < kfc_pkg::NUM_BASES) begin
        hit = sym_ok && (sym_i.base_symbol[1:0] == 2'(i));
      end else begin
        hit = pair_ok && (pair_idx == kfc_pkg::SLOT_W'(i));
      end
      cnt_inc[i] = cnt_q[i] + {{(kfc_pkg::CNT_W-1){1'b0}}, hit};
    end
  end

  assign cnt_upd = in_win ? cnt_inc : cnt_q;

  always_comb begin
    cnt_d      = cnt_q;
    prev_d     = prev_q;
    pos_d      = pos_q;
    job_push_o = 1'b0;
    if (accept_i) begin
      if (in_win) begin
        cnt_d  = cnt_inc;
        prev_d = sym_ok ? sym_i.base_symbol : kfc_pkg::NO_BASE;
        pos_d  = pos_q + 1'b1;
      end
      // hand the finished sequence to the back end and start over
      if (sym_i.seq_last) begin
        job_push_o = 1'b1;
        cnt_d      = '0;
        prev_d     = kfc_pkg::NO_BASE;
        pos_d      = '0;
      end
    end
  end

  assign job_o.counts = cnt_upd;
  assign job_o.window = window_i;
  assign job_o.order  = order_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      prev_q <= kfc_pkg::NO_BASE;
      pos_q  <= '0;
    end else begin
      cnt_q  <= cnt_d;
      prev_q <= prev_d;
      pos_q  <= pos_d;
    end
  end

endmodule
`default_nettype wire

### rtl/kfc_job_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
module kfc_job_fifo #(
  parameter int unsigned Depth = kfc_pkg::JOB_DEPTH
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire kfc_pkg::job_t data_i,
  input  wire logic          pop_i,
  output kfc_pkg::job_t      head_o,
  output logic               full_o,
  output logic               empty_o
);

  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;

  kfc_pkg::job_t         mem_q [Depth];
  kfc_pkg::job_t         mem_d [Depth];
  logic [CntW-1:0]       count_q, count_d;
  logic [PtrW-1:0]       wr_idx;

  assign full_o  = count_q == CntW'(Depth);
  assign empty_o = count_q == '0;
  assign head_o  = mem_q[0];
  assign wr_idx  = PtrW'(count_q - {{(CntW-1){1'b0}}, pop_i});

  always_comb begin
    mem_d = mem_q;
    if (pop_i) begin
      for (int i = 0; i < Depth - 1; i++) begin
        mem_d[i] = mem_q[i + 1];
      end
    end
    if (push_i) begin
      mem_d[wr_idx] = data_i;
    end
    count_d = count_q + {{(CntW-1){1'b0}}, push_i} - {{(CntW-1){1'b0}}, pop_i};
  end

  always_ff @(posedge clk_i) begin
    mem_q <= mem_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

endmodule
`default_nettype wire

### rtl/kfc_back.sv
`timescale 1ns / 1ps
`default_nettype none
module kfc_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          job_valid_i,
  input  wire kfc_pkg::job_t job_i,
  output logic               job_pop_o,
  input  wire logic          pop_i,
  output kfc_pkg::res_t      res_o,
  output logic               res_valid_o
);

  localparam int unsigned N = kfc_pkg::NUM_COUNTERS;
  localparam int unsigned CW = kfc_pkg::CNT_W;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  state_e                            state_q, state_d;
  logic [N-1:0][CW-1:0]              work_q, work_d;
  logic [kfc_pkg::WIN_W-1:0]         win_q, win_d;
  logic [kfc_pkg::ORD_W-1:0]         ord_q, ord_d;
  logic [kfc_pkg::SLOT_W-1:0]        slot_q, slot_d, last_slot;
  logic [kfc_pkg::STEP_W-1:0]        step_q, step_d;
  logic [kfc_pkg::NUM_W-1:0]         num_q, num_d;
  logic [CW-1:0]                     rem_q, rem_d;
  logic [kfc_pkg::FREQ_W-1:0]        quo_q, quo_d;
  kfc_pkg::res_t                     res_q, res_d;
  logic                              res_valid_q, res_valid_d;

  logic                              first_order;
  logic [CW-1:0]                     den;
  logic [CW:0]                       rem_sh, rem_sub;
  logic                              ge;
  logic                              load;

  assign first_order = slot_q < kfc_pkg::SLOT_W'(kfc_pkg::NUM_BASES);
  // denominator is window - k + 1
  assign den       = first_order ? win_q : win_q - 1'b1;
  assign last_slot = (ord_q == 2'd2) ? kfc_pkg::SLOT_W'(N - 1)
                                     : kfc_pkg::SLOT_W'(kfc_pkg::NUM_BASES - 1);

  assign rem_sh  = {rem_q, num_q[kfc_pkg::NUM_W-1]};
  assign ge      = rem_sh >= {1'b0, den};
  assign rem_sub = rem_sh - {1'b0, den};

  assign load = (state_q == ST_DONE) && (!res_valid_q || pop_i);

  always_comb begin
    state_d   = state_q;
    work_d    = work_q;
    win_d     = win_q;
    ord_d     = ord_q;
    slot_d    = slot_q;
    step_d    = step_q;
    num_d     = num_q;
    rem_d     = rem_q;
    quo_d     = quo_q;
    res_d     = res_q;
    job_pop_o = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (job_valid_i) begin
          job_pop_o = 1'b1;
          work_d    = job_i.counts;
          win_d     = job_i.window;
          ord_d     = job_i.order;
          slot_d    = '0;
          step_d    = '0;
          num_d     = {job_i.counts[0], {kfc_pkg::FRAC_W{1'b0}}};
          rem_d     = '0;
          quo_d     = '0;
          state_d   = ST_DIV;
        end
      end
      ST_DIV: begin
        // one quotient bit per cycle
        rem_d = ge ? rem_sub[CW-1:0] : rem_sh[CW-1:0];
        quo_d = {quo_q[kfc_pkg::FREQ_W-2:0], ge};
        num_d = {num_q[kfc_pkg::NUM_W-2:0], 1'b0};
        if (step_q == kfc_pkg::STEP_W'(kfc_pkg::NUM_W - 1)) begin
          state_d = ST_DONE;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      ST_DONE: begin
        if (load) begin
          res_d.kmer_order  = first_order ? 2'd1 : 2'd2;
          res_d.kmer_index  = first_order ? slot_q[kfc_pkg::IDX_W-1:0]
                            : kfc_pkg::IDX_W'(slot_q - kfc_pkg::SLOT_W'(kfc_pkg::NUM_BASES));
          res_d.match_count = work_q[0];
          res_d.frequency   = (den == '0) ? '0 : quo_q;
          res_d.run_last    = slot_q == last_slot;
          if (slot_q == last_slot) begin
            state_d = ST_IDLE;
          end else begin
            for (int i = 0; i < N - 1; i++) begin
              work_d[i] = work_q[i + 1];
            end
            slot_d  = slot_q + 1'b1;
            step_d  = '0;
            num_d   = {work_q[1], {kfc_pkg::FRAC_W{1'b0}}};
            rem_d   = '0;
            quo_d   = '0;
            state_d = ST_DIV;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign res_valid_d = (res_valid_q && !pop_i) || load;
  assign res_o       = res_q;
  assign res_valid_o = res_valid_q;

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
    win_q  <= win_d;
    ord_q  <= ord_d;
    num_q  <= num_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    res_q  <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      slot_q      <= '0;
      step_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      slot_q      <= slot_d;
      step_q      <= step_d;
      res_valid_q <= res_valid_d;
    end
  end

endmodule
`default_nettype wire

### rtl/kfc_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module kfc_checker (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          empty,
  input wire logic          pop,
  input wire kfc_pkg::res_t res_data_o
);

  // hold the waiting transaction while the receiver stalls
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(res_data_o)))
    else $error("result changed while stalled");

  a_order_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (res_data_o.kmer_order == 2'd1 || res_data_o.kmer_order == 2'd2))
    else $error("illegal k-mer order");

  a_one_mer_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && res_data_o.kmer_order == 2'd1) |-> (res_data_o.kmer_index[3:2] == 2'b00))
    else $error("1-mer index out of range");

  a_run_last_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && res_data_o.run_last) |->
      ((res_data_o.kmer_order == 2'd1 && res_data_o.kmer_index == 4'd3) ||
       (res_data_o.kmer_order == 2'd2 && res_data_o.kmer_index == 4'd15)))
    else $error("run_last not on the final k-mer");

endmodule

bind kmer_frequency_counter_unit kfc_checker u_kfc_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .empty      (empty),
  .pop        (pop),
  .res_data_o (res_data_o)
);
`default_nettype wire
